// ===== src/odo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_pkg
// Shared constants for the wheel odometry block.
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_TICK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_WHEEL_BASE = 1'b1;

    localparam logic [23:0] MPT_RESET = 24'd429497;
    localparam logic [15:0] IWB_RESET = 16'd8192;

    // 2^32 / pi
    localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;
    // CORDIC gain, Q2.30
    localparam logic [33:0] GAIN_Q30 = 34'd652032874;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int CS_W         = 24;   // cos / sin, Q1.22
    localparam int CR_W         = 34;   // CORDIC datapath

    typedef logic [31:0] atan_t;

    // atan(2^-i) as a 32 bit binary angle
    localparam atan_t ATAN_TABLE [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

// ===== src/differential_drive_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose tracker for a two-wheeled robot.
// ----------------------------------------------------------------------------
// One request at a time. A reset request (req_type = 1) goes to ST_DONE and is
// answered from there once the output is free. An encoder sample runs through
// bit-serial multipliers and an iterative CORDIC, one bit or one rotation per
// cycle: first the distance and tick difference, then the turn in radians,
// the binary-angle step, cos/sin and the x/y moves, in that order. The next
// request is taken as soon as the sequencer is back in idle, even while the
// last result still waits on the output.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [31:0]                   left_position,
    input  logic [31:0]                   right_position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            pose_x,
    output logic signed [31:0]            pose_y,
    output logic signed [15:0]            heading
);

    import odo_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIST = 3'd1;
    localparam logic [2:0] ST_RAD  = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_ROT  = 3'd4;
    localparam logic [2:0] ST_MOVE = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam int STEP_LO = 61 - ANGLE_BITS;

    logic [2:0]            state_reg, state_next;
    logic [23:0]           mpt_reg;
    logic [15:0]           iwb_reg;
    logic [31:0]           last_left_reg, last_right_reg;
    logic signed [31:0]    pos_x_reg, pos_x_next;
    logic signed [31:0]    pos_y_reg, pos_y_next;
    logic [ANGLE_BITS-1:0] head_reg, head_next;
    logic [ANGLE_BITS-1:0] head_new_reg, head_new_next;
    logic                  clr_reg, clr_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  accept;
    logic [31:0]           dl, dr;
    logic [32:0]           sum_a, diff_a;
    logic                  start_dist, start_step, start_rot, start_move;
    logic [57:0]           sum_p, diff_p;
    logic [56:0]           rad_p;
    logic [60:0]           step_p;
    logic [63:0]           x_p, y_p;
    logic                  sum_done, diff_done, rad_done, step_done, x_done, y_done;
    logic [CS_W-1:0]       cos_q, sin_q;
    logic                  rot_done;
    logic [ANGLE_BITS-1:0] head_sum;
    logic [63:0]           x_rnd, y_rnd;
    logic signed [31:0]    x_sat, y_sat;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic [41:0] inc);
        logic [42:0] s;
        s = {{11{p[31]}}, p} + {inc[41], inc};
        if (s[42:31] == {12{s[42]}})
            sat_add = s[31:0];
        else if (s[42])
            sat_add = 32'sh8000_0000;
        else
            sat_add = 32'sh7FFF_FFFF;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign dl     = left_position - last_left_reg;
    assign dr     = right_position - last_right_reg;
    assign sum_a  = {dl[31], dl} + {dr[31], dr};
    assign diff_a = {dl[31], dl} - {dr[31], dr};

    assign start_dist = accept && !req_type;
    assign start_step = (state_reg == ST_RAD) && rad_done;
    assign start_rot  = (state_reg == ST_STEP) && step_done;
    assign start_move = (state_reg == ST_ROT) && rot_done;

    odo_mul #(.A_W(33), .B_W(24), .B_SIGNED(1'b0), .P_W(58)) u_mul_sum (
        .clk(clk), .rst_n(rst_n), .start(start_dist),
        .a(sum_a), .b(mpt_reg), .prod(sum_p), .done(sum_done)
    );

    odo_mul #(.A_W(33), .B_W(24), .B_SIGNED(1'b0), .P_W(58)) u_mul_diff (
        .clk(clk), .rst_n(rst_n), .start(start_dist),
        .a(diff_a), .b(mpt_reg), .prod(diff_p), .done(diff_done)
    );

    // turn in radians * 2^28
    odo_mul #(.A_W(41), .B_W(16), .B_SIGNED(1'b0), .P_W(57)) u_mul_rad (
        .clk(clk), .rst_n(rst_n), .start((state_reg == ST_DIST) && diff_done),
        .a(diff_p[56:16]), .b(iwb_reg), .prod(rad_p), .done(rad_done)
    );

    // only the low 61 bits matter for the binary angle
    odo_mul #(.A_W(57), .B_W(32), .B_SIGNED(1'b0), .P_W(61)) u_mul_step (
        .clk(clk), .rst_n(rst_n), .start(start_step),
        .a(rad_p), .b(INV_PI_Q32), .prod(step_p), .done(step_done)
    );

    assign head_sum = head_reg + step_p[60:STEP_LO];

    odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(start_rot), .angle(head_sum),
        .cos_q(cos_q), .sin_q(sin_q), .done(rot_done)
    );

    odo_mul #(.A_W(40), .B_W(CS_W), .B_SIGNED(1'b1), .P_W(64)) u_mul_x (
        .clk(clk), .rst_n(rst_n), .start(start_move),
        .a(sum_p[56:17]), .b(cos_q), .prod(x_p), .done(x_done)
    );

    odo_mul #(.A_W(40), .B_W(CS_W), .B_SIGNED(1'b1), .P_W(64)) u_mul_y (
        .clk(clk), .rst_n(rst_n), .start(start_move),
        .a(sum_p[56:17]), .b(sin_q), .prod(y_p), .done(y_done)
    );

    assign x_rnd = x_p + 64'd2097152;
    assign y_rnd = y_p + 64'd2097152;
    assign x_sat = sat_add(pos_x_reg, x_rnd[63:22]);
    assign y_sat = sat_add(pos_y_reg, y_rnd[63:22]);

    always_comb
    begin
        state_next     = state_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        head_next      = head_reg;
        head_new_next  = head_new_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    clr_next   = req_type;
                    state_next = req_type ? ST_DONE : ST_DIST;
                end
            end
            ST_DIST:
            begin
                if (diff_done)
                    state_next = ST_RAD;
            end
            ST_RAD:
            begin
                if (rad_done)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (step_done)
                begin
                    head_new_next = head_sum;
                    state_next    = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (rot_done)
                    state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                if (x_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (clr_reg)
                    begin
                        pos_x_next = '0;
                        pos_y_next = '0;
                        head_next  = '0;
                    end
                    else
                    begin
                        pos_x_next = x_sat;
                        pos_y_next = y_sat;
                        head_next  = head_new_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            mpt_reg        <= MPT_RESET;
            iwb_reg        <= IWB_RESET;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            head_reg       <= '0;
            clr_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            head_reg      <= head_next;
            clr_reg       <= clr_next;
            if (accept)
            begin
                last_left_reg  <= left_position;
                last_right_reg <= right_position;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_METERS_PER_TICK:    mpt_reg <= cfg_data;
                    CFG_INVERSE_WHEEL_BASE: iwb_reg <= cfg_data[15:0];
                    default:                mpt_reg <= mpt_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_new_reg <= head_new_next;
    end

    assign out_valid = out_valid_reg;
    assign pose_x    = pos_x_reg;
    assign pose_y    = pos_y_reg;

    generate
        if (ANGLE_BITS >= 16)
        begin : g_head_wide
            assign heading = head_reg[ANGLE_BITS-1 -: 16];
        end
        else
        begin : g_head_narrow
            assign heading = {head_reg, {(16-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    // unused completion flags of the paired multipliers
    logic unused_done;
    assign unused_done = sum_done ^ y_done;

endmodule

// ===== src/odo_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module odo_mul #(
    parameter int A_W      = 33,
    parameter int B_W      = 24,
    parameter bit B_SIGNED = 1'b0,
    parameter int P_W      = 58
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic [P_W-1:0] prod,
    output logic           done
);

    localparam int CNT_W = $clog2(B_W);
    localparam int EXT_W = P_W - A_W;

    logic [P_W-1:0]   mc_reg, mc_next;
    logic [B_W-1:0]   mp_reg, mp_next;
    logic [P_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             last;
    logic [P_W-1:0]   partial;

    assign last    = (cnt_reg == CNT_W'(B_W - 1));
    assign partial = mp_reg[0] ? mc_reg : '0;

    always_comb
    begin
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            mc_next   = {{EXT_W{a[A_W-1]}}, a};
            mp_next   = b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // top bit of a signed multiplier carries negative weight
            if (B_SIGNED && last)
                acc_next = acc_reg - partial;
            else
                acc_next = acc_reg + partial;
            mc_next  = {mc_reg[P_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        acc_reg <= acc_next;
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ===== src/odo_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module odo_cordic #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ANGLE_BITS-1:0]        angle,
    output logic [odo_pkg::CS_W-1:0]     cos_q,
    output logic [odo_pkg::CS_W-1:0]     sin_q,
    output logic                         done
);

    import odo_pkg::*;

    localparam int PAD_W = 32 - ANGLE_BITS;

    logic signed [CR_W-1:0] x_reg, x_next;
    logic signed [CR_W-1:0] y_reg, y_next;
    logic signed [CR_W-1:0] z_reg, z_next;
    logic [ATAN_IDX_W-1:0]  cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   flip_reg, flip_next;

    logic [31:0]            a32;
    logic signed [31:0]     z32;
    logic                   fold;
    logic [31:0]            a_fold;
    logic signed [CR_W-1:0] xs, ys, at;
    logic                   last;
    logic signed [CR_W-1:0] xf, yf;

    assign a32    = {angle, {PAD_W{1'b0}}};
    assign z32    = signed'(a32);
    assign fold   = (z32 > 32'sh4000_0000) || (z32 < -32'sh4000_0000);
    assign a_fold = fold ? (a32 + 32'h8000_0000) : a32;

    assign xs   = x_reg >>> cnt_reg;
    assign ys   = y_reg >>> cnt_reg;
    assign at   = {2'b00, ATAN_TABLE[cnt_reg]};
    assign last = (cnt_reg == ATAN_IDX_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = GAIN_Q30;
            y_next    = '0;
            z_next    = {{(CR_W-32){a_fold[31]}}, a_fold};
            cnt_next  = '0;
            flip_next = fold;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CR_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    // undo the half-turn fold, round half up to Q1.22
    assign xf = (flip_reg ? -x_reg : x_reg) + CR_W'(128);
    assign yf = (flip_reg ? -y_reg : y_reg) + CR_W'(128);

    assign cos_q = xf[CS_W+7:8];
    assign sin_q = yf[CS_W+7:8];
    assign done  = done_reg;

endmodule
